[src/sid_pkg.sv]
// ----------------------------------------------------------------------------
// sid_pkg
// shared widths, codes and types of the species id decoder
// ----------------------------------------------------------------------------
package sid_pkg;

    localparam int NUM_SPECIES_DEF = 4;
    localparam int REG_SPECIES     = 4;

    localparam int ID_W      = 28;
    localparam int MOL_W     = 16;
    localparam int PART_W    = 10;
    localparam int MOL_END_W = 18;
    localparam int DIFF_W    = 26;
    localparam int SPC_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // register index bases
    localparam int CFG_MOL_BASE   = 0;
    localparam int CFG_PARTS_BASE = 4;

    // opcodes
    localparam logic OP_MOL  = 1'b0;
    localparam logic OP_PART = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_DIV
    } t_state;

    // running end offsets handed from cell to cell
    typedef struct packed {
        logic [MOL_END_W-1:0] mol_end;
        logic [ID_W-1:0]      part_end;
    } t_link;

    // lookup answer of one cell
    typedef struct packed {
        logic              hit;
        logic [DIFF_W-1:0] diff;
        logic [PART_W-1:0] parts;
    } t_cell_res;

    // divider result
    typedef struct packed {
        logic              done;
        logic [MOL_W-1:0]  quo;
        logic [PART_W-1:0] rem;
    } t_div_res;

endpackage

[src/sid_cell.sv]
// ----------------------------------------------------------------------------
// sid_cell
// one species: holds its counts, extends the running offsets, checks an id
// ----------------------------------------------------------------------------
module sid_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_mol,
    input  logic                          i_wr_parts,
    input  logic [sid_pkg::CFG_DAT_W-1:0] i_wr_data,
    input  sid_pkg::t_link                i_prev,
    input  logic                          i_op,
    input  logic [sid_pkg::ID_W-1:0]      i_id,
    output sid_pkg::t_link                o_next,
    output sid_pkg::t_cell_res            o_res
);

    logic [sid_pkg::MOL_W-1:0]  r_mol;
    logic [sid_pkg::PART_W-1:0] r_parts;
    logic [sid_pkg::DIFF_W-1:0] r_prod;
    sid_pkg::t_link             r_end;

    logic [sid_pkg::ID_W-1:0] start_off;
    logic [sid_pkg::ID_W-1:0] end_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mol   <= '0;
            r_parts <= '0;
            r_prod  <= '0;
            r_end   <= '0;
        end else begin
            if (i_wr_mol) begin
                r_mol <= i_wr_data[sid_pkg::MOL_W-1:0];
            end
            if (i_wr_parts) begin
                r_parts <= i_wr_data[sid_pkg::PART_W-1:0];
            end
            r_prod           <= sid_pkg::DIFF_W'(r_mol) * sid_pkg::DIFF_W'(r_parts);
            r_end.mol_end    <= i_prev.mol_end + sid_pkg::MOL_END_W'(r_mol);
            r_end.part_end   <= i_prev.part_end + sid_pkg::ID_W'(r_prod);
        end
    end

    always_comb begin
        if (i_op == sid_pkg::OP_PART) begin
            start_off = i_prev.part_end;
            end_off   = r_end.part_end;
        end else begin
            start_off = sid_pkg::ID_W'(i_prev.mol_end);
            end_off   = sid_pkg::ID_W'(r_end.mol_end);
        end
        o_res.hit   = (i_id >= start_off) && (i_id < end_off);
        o_res.diff  = sid_pkg::DIFF_W'(i_id - start_off);
        o_res.parts = r_parts;
    end

    assign o_next = r_end;

endmodule

[src/sid_div.sv]
// ----------------------------------------------------------------------------
// sid_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sid_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [sid_pkg::DIFF_W-1:0]  i_dividend,
    input  logic [sid_pkg::PART_W-1:0]  i_divisor,
    output sid_pkg::t_div_res           o_res
);

    localparam int CNT_W = $clog2(sid_pkg::MOL_W);

    logic                       r_busy;
    logic                       r_done;
    logic [CNT_W-1:0]           r_cnt;
    logic [sid_pkg::PART_W-1:0] r_div;
    logic [sid_pkg::PART_W-1:0] r_rem;
    logic [sid_pkg::MOL_W-1:0]  r_quo;

    logic [sid_pkg::PART_W:0]   trial;
    logic                       take;
    logic [sid_pkg::PART_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quo[sid_pkg::MOL_W-1]};
        take  = trial >= {1'b0, r_div};
        if (take) begin
            n_rem = sid_pkg::PART_W'(trial - {1'b0, r_div});
        end else begin
            n_rem = trial[sid_pkg::PART_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(sid_pkg::MOL_W - 1));
            if (i_load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(sid_pkg::MOL_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // high bits of the dividend are below the divisor, so they seed the remainder
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_div <= i_divisor;
            r_rem <= i_dividend[sid_pkg::DIFF_W-1:sid_pkg::MOL_W];
            r_quo <= i_dividend[sid_pkg::MOL_W-1:0];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[sid_pkg::MOL_W-2:0], take};
        end
    end

    assign o_res.done = r_done;
    assign o_res.quo  = r_quo;
    assign o_res.rem  = r_rem;

endmodule

[src/species_id_decoder.sv]
// ----------------------------------------------------------------------------
// species_id_decoder
// maps a global molecule or part id to species, molecule and part indices
// ----------------------------------------------------------------------------
// channel   | direction | handshake          | payload
// input     | in        | start / busy       | i_opcode, i_global_id
// result    | out       | o_strobe           | o_species_index, o_molecule_index,
//           |           |                    | o_part_index, o_out_of_range
// config    | in        | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// molecule ids and out of range ids: decided in S_FIND, then registered to the strobe
// part ids: S_FIND loads the serial divider, whose 16 steps run in S_DIV before the strobe
// a config write keeps busy high while the offsets ripple down the cell row
// busy is low after reset release and high while a transaction or that ripple runs
// o_strobe lasts one cycle and cannot be held off
// ----------------------------------------------------------------------------
module species_id_decoder #(
    parameter int NUM_SPECIES = sid_pkg::NUM_SPECIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_opcode,
    input  logic [sid_pkg::ID_W-1:0]      i_global_id,
    input  logic                          i_cfg_we,
    input  logic [sid_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sid_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output logic                          o_strobe,
    output logic [sid_pkg::SPC_W-1:0]     o_species_index,
    output logic [sid_pkg::MOL_W-1:0]     o_molecule_index,
    output logic [sid_pkg::PART_W-1:0]    o_part_index,
    output logic                          o_out_of_range
);

    localparam int IDX_W  = (NUM_SPECIES > 1) ? $clog2(NUM_SPECIES) : 1;
    localparam int SETTLE = NUM_SPECIES + 2;
    localparam int SET_W  = $clog2(SETTLE + 1);

    sid_pkg::t_state r_state, n_state;

    logic [SET_W-1:0]           r_settle;
    logic                       r_op;
    logic [sid_pkg::ID_W-1:0]   r_id;

    logic                       r_strobe, n_strobe;
    logic [sid_pkg::SPC_W-1:0]  r_species, n_species;
    logic [sid_pkg::MOL_W-1:0]  r_mol, n_mol;
    logic [sid_pkg::PART_W-1:0] r_part, n_part;
    logic                       r_oor, n_oor;

    logic                       accept;
    logic                       div_load;
    sid_pkg::t_div_res          div_res;

    sid_pkg::t_link             links [NUM_SPECIES+1];
    sid_pkg::t_cell_res         cres  [NUM_SPECIES];

    logic                       any_hit;
    logic [IDX_W-1:0]           sel_idx;
    logic [sid_pkg::DIFF_W-1:0] sel_diff;
    logic [sid_pkg::PART_W-1:0] sel_parts;

    assign links[0] = '0;

    for (genvar g = 0; g < NUM_SPECIES; g++) begin : g_cell
        logic wr_mol;
        logic wr_parts;
        if (g < sid_pkg::REG_SPECIES) begin : g_reg
            assign wr_mol   = i_cfg_we &&
                (i_cfg_idx == sid_pkg::CFG_IDX_W'(sid_pkg::CFG_MOL_BASE + g));
            assign wr_parts = i_cfg_we &&
                (i_cfg_idx == sid_pkg::CFG_IDX_W'(sid_pkg::CFG_PARTS_BASE + g));
        end else begin : g_noreg
            assign wr_mol   = 1'b0;
            assign wr_parts = 1'b0;
        end
        sid_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr_mol   (wr_mol),
            .i_wr_parts (wr_parts),
            .i_wr_data  (i_cfg_data),
            .i_prev     (links[g]),
            .i_op       (r_op),
            .i_id       (r_id),
            .o_next     (links[g+1]),
            .o_res      (cres[g])
        );
    end

    // ranges are disjoint, so at most one cell hits
    always_comb begin
        any_hit   = 1'b0;
        sel_idx   = '0;
        sel_diff  = '0;
        sel_parts = '0;
        for (int i = 0; i < NUM_SPECIES; i++) begin
            if (cres[i].hit) begin
                any_hit   = 1'b1;
                sel_idx   = sel_idx | IDX_W'(i);
                sel_diff  = sel_diff | cres[i].diff;
                sel_parts = sel_parts | cres[i].parts;
            end
        end
    end

    sid_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (div_load),
        .i_dividend (sel_diff),
        .i_divisor  (sel_parts),
        .o_res      (div_res)
    );

    assign busy   = (r_state != sid_pkg::S_IDLE) || (r_settle != '0);
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sid_pkg::S_IDLE;
            r_settle <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_settle <= SET_W'(SETTLE);
            end else if (r_settle != '0) begin
                r_settle <= r_settle - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= i_opcode;
            r_id <= i_global_id;
        end
        r_species <= n_species;
        r_mol     <= n_mol;
        r_part    <= n_part;
        r_oor     <= n_oor;
    end

    always_comb begin
        n_state   = r_state;
        n_strobe  = 1'b0;
        n_species = r_species;
        n_mol     = r_mol;
        n_part    = r_part;
        n_oor     = r_oor;
        div_load  = 1'b0;
        unique case (r_state)
            sid_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = sid_pkg::S_FIND;
                end
            end
            sid_pkg::S_FIND: begin
                n_species = any_hit ? sid_pkg::SPC_W'(sel_idx) : '0;
                n_oor     = !any_hit;
                if (!any_hit) begin
                    n_mol    = '0;
                    n_part   = '0;
                    n_strobe = 1'b1;
                    n_state  = sid_pkg::S_IDLE;
                end else if (r_op == sid_pkg::OP_MOL) begin
                    n_mol    = sel_diff[sid_pkg::MOL_W-1:0];
                    n_part   = '0;
                    n_strobe = 1'b1;
                    n_state  = sid_pkg::S_IDLE;
                end else begin
                    div_load = 1'b1;
                    n_state  = sid_pkg::S_DIV;
                end
            end
            sid_pkg::S_DIV: begin
                if (div_res.done) begin
                    n_mol    = div_res.quo;
                    n_part   = div_res.rem;
                    n_strobe = 1'b1;
                    n_state  = sid_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sid_pkg::S_IDLE;
            end
        endcase
    end

    assign o_strobe         = r_strobe;
    assign o_species_index  = r_species;
    assign o_molecule_index = r_mol;
    assign o_part_index     = r_part;
    assign o_out_of_range   = r_oor;

endmodule

[src/sid_checker.sv]
// ----------------------------------------------------------------------------
// sid_checker
// port level checks of the species id decoder
// ----------------------------------------------------------------------------
module sid_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          i_cfg_we,
    input  logic                          o_strobe,
    input  logic [sid_pkg::SPC_W-1:0]     o_species_index,
    input  logic [sid_pkg::MOL_W-1:0]     o_molecule_index,
    input  logic [sid_pkg::PART_W-1:0]    o_part_index,
    input  logic                          o_out_of_range
);

    // an accepted transaction holds off the next one
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // a config write blocks new transactions while offsets settle
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> busy)
        else $error("busy not raised after config write");

    // a result takes a single strobe
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("strobe held for more than one cycle");

    // out of range results carry zero indices
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_out_of_range |->
            o_species_index == '0 && o_molecule_index == '0 && o_part_index == '0)
        else $error("out of range result with nonzero indices");

endmodule

bind species_id_decoder sid_checker u_sid_checker (.*);

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the species id decoder: register settings are
// loaded while the block is idle, molecule and part ids are decoded against
// an in-bench prediction of species, molecule, part and range flag
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int   REG_SPECIES    = sid_pkg::REG_SPECIES;
    localparam int   ID_W           = sid_pkg::ID_W;
    localparam int   MOL_W          = sid_pkg::MOL_W;
    localparam int   PART_W         = sid_pkg::PART_W;
    localparam int   MOL_END_W      = sid_pkg::MOL_END_W;
    localparam int   SPC_W          = sid_pkg::SPC_W;
    localparam int   CFG_IDX_W      = sid_pkg::CFG_IDX_W;
    localparam int   CFG_DAT_W      = sid_pkg::CFG_DAT_W;
    localparam int   CFG_MOL_BASE   = sid_pkg::CFG_MOL_BASE;
    localparam int   CFG_PARTS_BASE = sid_pkg::CFG_PARTS_BASE;
    localparam logic OP_MOL         = sid_pkg::OP_MOL;
    localparam logic OP_PART        = sid_pkg::OP_PART;

    localparam int N_SPC  = sid_pkg::NUM_SPECIES_DEF;
    localparam int N_REGS = 2 * REG_SPECIES;

    typedef struct packed {
        logic [SPC_W-1:0]  spc;
        logic [MOL_W-1:0]  mol;
        logic [PART_W-1:0] part;
        logic              oor;
    } t_decode;

    class id_decode_checker;
        logic [MOL_W-1:0]     mol_count [REG_SPECIES];
        logic [PART_W-1:0]    parts_per_mol [REG_SPECIES];
        logic [MOL_END_W-1:0] mol_base [N_SPC+1];
        logic [ID_W-1:0]      part_base [N_SPC+1];
        t_decode              pending_decodes [$];
        int                   n_checked;
        int                   n_oor;
        int                   n_errors;

        function new();
            foreach (mol_count[i]) begin
                mol_count[i] = '0;
                parts_per_mol[i] = '0;
            end
            n_checked = 0;
            n_oor = 0;
            n_errors = 0;
            rebuild_bases();
        endfunction

        function void rebuild_bases();
            logic [MOL_W-1:0]  m;
            logic [PART_W-1:0] p;
            mol_base[0] = '0;
            part_base[0] = '0;
            for (int s = 0; s < N_SPC; s++) begin
                m = (s < REG_SPECIES) ? mol_count[s] : '0;
                p = (s < REG_SPECIES) ? parts_per_mol[s] : '0;
                mol_base[s+1] = mol_base[s] + MOL_END_W'(m);
                part_base[s+1] = part_base[s] + ID_W'(m) * ID_W'(p);
            end
        endfunction

        function void note_reg(int idx, logic [CFG_DAT_W-1:0] data);
            if (idx < CFG_PARTS_BASE) begin
                mol_count[idx - CFG_MOL_BASE] = data;
            end else if (idx < CFG_PARTS_BASE + REG_SPECIES) begin
                parts_per_mol[idx - CFG_PARTS_BASE] = data[PART_W-1:0];
            end else begin
                return;
            end
            rebuild_bases();
        endfunction

        function logic [ID_W-1:0] base_of(logic op, int s);
            return (op == OP_PART) ? part_base[s] : ID_W'(mol_base[s]);
        endfunction

        function t_decode decode_id(logic op, logic [ID_W-1:0] id);
            t_decode           r;
            logic [ID_W-1:0]   diff;
            logic [PART_W-1:0] p;
            bit                found;
            r = '{spc: '0, mol: '0, part: '0, oor: 1'b1};
            found = 0;
            for (int s = 0; s < N_SPC; s++) begin
                if (!found && id >= base_of(op, s) && id < base_of(op, s + 1)) begin
                    found = 1;
                    diff = id - base_of(op, s);
                    r.spc = SPC_W'(s);
                    r.oor = 1'b0;
                    if (op == OP_PART) begin
                        p = parts_per_mol[s];
                        if (p != 0) begin
                            r.mol = MOL_W'(diff / ID_W'(p));
                            r.part = PART_W'(diff % ID_W'(p));
                        end
                    end else begin
                        r.mol = diff[MOL_W-1:0];
                    end
                end
            end
            return r;
        endfunction

        function void accept_id(logic op, logic [ID_W-1:0] id);
            pending_decodes.push_back(decode_id(op, id));
        endfunction

        function int pending();
            return pending_decodes.size();
        endfunction

        function void check_decode(t_decode got);
            t_decode exp;
            if (pending_decodes.size() == 0) begin
                $display("%0t: result with no transaction pending: spc %0d mol %0d part %0d oor %0d",
                         $time, got.spc, got.mol, got.part, got.oor);
                n_errors++;
                return;
            end
            exp = pending_decodes.pop_front();
            n_checked++;
            if (exp.oor) n_oor++;
            if (got.spc !== exp.spc) begin
                $display("%0t: species_index expected %0d actual %0d", $time, exp.spc, got.spc);
                n_errors++;
            end
            if (got.mol !== exp.mol) begin
                $display("%0t: molecule_index expected %0d actual %0d", $time, exp.mol, got.mol);
                n_errors++;
            end
            if (got.part !== exp.part) begin
                $display("%0t: part_index expected %0d actual %0d", $time, exp.part, got.part);
                n_errors++;
            end
            if (got.oor !== exp.oor) begin
                $display("%0t: out_of_range expected %0d actual %0d", $time, exp.oor, got.oor);
                n_errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_opcode;
    logic [ID_W-1:0]      i_global_id;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic                 o_strobe;
    logic [SPC_W-1:0]     o_species_index;
    logic [MOL_W-1:0]     o_molecule_index;
    logic [PART_W-1:0]    o_part_index;
    logic                 o_out_of_range;

    id_decode_checker     sb;
    logic [CFG_DAT_W-1:0] reg_vals [N_REGS];
    int                   idle_pct;
    int                   n_mol_ids;
    int                   n_part_ids;
    int                   n_settings;

    species_id_decoder DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_global_id      (i_global_id),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_strobe         (o_strobe),
        .o_species_index  (o_species_index),
        .o_molecule_index (o_molecule_index),
        .o_part_index     (o_part_index),
        .o_out_of_range   (o_out_of_range)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            sb.check_decode('{spc: o_species_index, mol: o_molecule_index,
                              part: o_part_index, oor: o_out_of_range});
        end
    end

    task automatic write_reg(input int idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_IDX_W'(idx);
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.note_reg(idx, data);
        i_cfg_we <= 1'b0;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic apply_regs();
        for (int r = 0; r < N_REGS; r++) write_reg(r, reg_vals[r]);
        n_settings++;
    endtask

    task automatic send_id(input logic op, input logic [ID_W-1:0] id);
        start <= 1'b1;
        i_opcode <= op;
        i_global_id <= id;
        do @(posedge i_clk); while (busy);
        sb.accept_id(op, id);
        if (op == OP_PART) n_part_ids++;
        else n_mol_ids++;
    endtask

    task automatic maybe_idle();
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // in-range ids, ids around species boundaries, and ids anywhere
    function automatic logic [ID_W-1:0] pick_id(logic op);
        logic [ID_W-1:0] total;
        int              mode;
        total = sb.base_of(op, N_SPC);
        mode = $urandom_range(9);
        if (mode < 6 && total != 0) return ID_W'($urandom_range(total - 1));
        if (mode < 8) begin
            return ID_W'(sb.base_of(op, $urandom_range(N_SPC)) + $urandom_range(2) - 1);
        end
        return ID_W'($urandom());
    endfunction

    task automatic fill_phase_regs(input int ph);
        for (int r = 0; r < N_REGS; r++) begin
            case (ph)
                0: reg_vals[r] = (r < CFG_PARTS_BASE) ? 16'hFFFF : 16'h03FF;
                2: reg_vals[r] = (r < CFG_PARTS_BASE) ? CFG_DAT_W'($urandom_range(4))
                                                      : CFG_DAT_W'($urandom_range(3));
                3: reg_vals[r] = ($urandom_range(2) == 0) ? '0 : CFG_DAT_W'($urandom());
                4: reg_vals[r] = (r < CFG_PARTS_BASE) ? CFG_DAT_W'($urandom_range(300))
                                                      : CFG_DAT_W'(1);
                5: reg_vals[r] = (r < CFG_PARTS_BASE) ? CFG_DAT_W'($urandom_range(2000))
                                                      : CFG_DAT_W'($urandom_range(1023));
                default: reg_vals[r] = CFG_DAT_W'($urandom());
            endcase
        end
    endtask

    initial begin
        sb = new();
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_opcode <= OP_MOL;
        i_global_id <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        idle_pct = 7;
        n_mol_ids = 0;
        n_part_ids = 0;
        n_settings = 1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting: every id is out of range
        send_id(OP_MOL, '0);
        send_id(OP_PART, '1);
        wait_drained();

        // empty species 1, species 2 without parts, species 3 at full size
        reg_vals = '{16'd3, 16'd0, 16'd5, 16'hFFFF, 16'd2, 16'd7, 16'd0, 16'd1023};
        apply_regs();
        send_id(OP_MOL, 28'd0);
        send_id(OP_MOL, 28'd2);
        send_id(OP_MOL, 28'd3);
        send_id(OP_MOL, 28'd7);
        send_id(OP_MOL, 28'd8);
        send_id(OP_MOL, 28'd65542);
        send_id(OP_MOL, 28'd65543);
        send_id(OP_MOL, '1);
        send_id(OP_PART, 28'd0);
        send_id(OP_PART, 28'd1);
        send_id(OP_PART, 28'd5);
        send_id(OP_PART, 28'd6);
        send_id(OP_PART, 28'd7);
        send_id(OP_PART, 28'd1029);
        send_id(OP_PART, 28'd67042310);
        send_id(OP_PART, 28'd67042311);
        send_id(OP_PART, '1);

        for (int ph = 0; ph < 6; ph++) begin
            logic op;
            wait_drained();
            fill_phase_regs(ph);
            apply_regs();
            idle_pct = (ph < 2) ? 7 : (ph < 4) ? 72 : 0;
            for (int k = 0; k < 80; k++) begin
                op = 1'($urandom_range(1));
                maybe_idle();
                send_id(op, pick_id(op));
            end
        end

        wait_drained();
        repeat (25) @(posedge i_clk);
        $display("tb_top: %0d molecule ids and %0d part ids decoded over %0d register settings",
                 n_mol_ids, n_part_ids, n_settings);
        $display("tb_top: %0d results checked, %0d out of range, %0d mismatches",
                 sb.n_checked, sb.n_oor, sb.n_errors + sb.pending());
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("tb_top: timeout");
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
